// File: rtl/sbda_pkg.sv
// Package for the signed binary to decimal ASCII converter.
// Holds the controller states, command and status structs and character codes.
// No dependencies.
package sbda_pkg;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam int         RADIX      = 10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic skip;
		logic put_sign;
		logic put_digit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic top_zero;
		logic more_digits;
		logic neg;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic [6:0] character;
		logic       last;
	} char_item_t;

endpackage

// File: rtl/sbda_stream_if.sv
// Valid/ready stream channel carrying one item of type T.
// Depends on nothing; payload types come from sbda_pkg at instantiation.
interface sbda_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sbda_ctrl.sv
// Controller state machine for the converter: sequences load, conversion,
// leading-zero skip and character output. Depends on sbda_pkg.
module sbda_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sbda_pkg::status_t status,
	output sbda_pkg::cmd_t    cmd
);
	import sbda_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (status.conv_done) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!(status.top_zero && status.more_digits)) begin
					state_d = status.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (status.out_free) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free && !status.more_digits) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: cmd.shift = 1'b1;
			ST_SKIP: cmd.skip = status.top_zero && status.more_digits;
			ST_SIGN: cmd.put_sign = status.out_free;
			ST_EMIT: cmd.put_digit = status.out_free;
			default: ;
		endcase
	end

	a_conv_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV && !status.conv_done |=> state_q == ST_CONV)
		else $error("conversion left early");
	a_sign_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_sign |=> state_q == ST_EMIT)
		else $error("sign not followed by digits");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("input taken outside idle");

endmodule

// File: rtl/sbda_datapath.sv
// Datapath for the converter: magnitude shift register, double-dabble BCD
// register, digit counters and the output character register. Depends on sbda_pkg.
module sbda_datapath #(
	parameter int VALUE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [VALUE_BITS-1:0]   value,
	input  logic                    out_ready,
	input  sbda_pkg::cmd_t          cmd,
	output sbda_pkg::status_t       status,
	output logic                    out_valid,
	output logic [6:0]              out_char,
	output logic                    out_last
);
	import sbda_pkg::*;

	localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W  = DIGITS * 4;
	localparam int CNT_W  = $clog2(VALUE_BITS);
	localparam int REM_W  = $clog2(DIGITS + 1);

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [CNT_W-1:0]      cnt_q;
	logic [REM_W-1:0]      rem_q;
	logic                  neg_q;
	logic                  valid_q;
	logic [6:0]            char_q;
	logic                  last_q;
	logic [3:0]            top_digit;
	logic                  out_free;

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign out_free  = !valid_q || out_ready;

	always_comb begin
		logic [3:0] dig;
		bcd_adj = bcd_q;
		for (int i = 0; i < DIGITS; i++) begin
			dig = bcd_q[i*4 +: 4];
			bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				rem_q <= REM_W'(DIGITS);
			end else if (cmd.shift) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.skip || cmd.put_digit) begin
				rem_q <= rem_q - 1'b1;
			end
			if (cmd.put_sign || cmd.put_digit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[VALUE_BITS-1];
			mag_q <= value[VALUE_BITS-1] ? ~value + 1'b1 : value;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
		end else if (cmd.skip || cmd.put_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
		if (cmd.put_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.put_digit) begin
			char_q <= 7'(CHAR_ZERO + {3'd0, top_digit});
			last_q <= (rem_q == REM_W'(1));
		end
	end

	assign status.conv_done   = (cnt_q == CNT_W'(VALUE_BITS - 1));
	assign status.top_zero    = (top_digit == 4'd0);
	assign status.more_digits = (rem_q != REM_W'(1));
	assign status.neg         = neg_q;
	assign status.out_free    = out_free;

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_digit |=> valid_q && char_q >= CHAR_ZERO
			&& char_q <= 7'(CHAR_ZERO + 7'(RADIX - 1)))
		else $error("digit outside decimal range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |-> !(cmd.put_sign || cmd.put_digit))
		else $error("pending item overwritten");
	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> bcd_q == '0 && cnt_q == '0)
		else $error("load did not clear conversion state");

endmodule

// File: rtl/signed_binary_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII converter.
// Joins sbda_ctrl and sbda_datapath; uses sbda_pkg and sbda_stream_if.
//
// Usage:
//   number : sink channel, one signed two's complement VALUE_BITS-bit integer per item.
//   text   : source channel, one ASCII character per item ('-' or '0'..'9'),
//            most significant digit first; last is set on the final character.
// Sequence per number:
//   accept, VALUE_BITS double-dabble shift steps in the BCD register,
//   leading zero digits dropped, a sign when negative, then the digits;
//   dropped and emitted digits always total DIGITS (10 at 32 bits). The
//   single BCD shift/adjust unit sets the conversion time.
//   A new number is taken only once the previous one has been fully
//   sequenced; its last character may still sit in the output register.
// Reset: arst_n clears the controller and the output valid flag; no item
//   is in flight afterwards.
// Stall: while text.ready is low the output register holds its character
//   and the controller waits before issuing another; nothing is lost or repeated.
module signed_binary_to_decimal_ascii #(
	parameter int VALUE_BITS = 32
) (
	input logic          clk,
	input logic          arst_n,
	sbda_stream_if.sink   number,
	sbda_stream_if.source text
);
	import sbda_pkg::*;

	cmd_t       cmd;
	status_t    status;
	logic       in_ready;
	logic       out_valid;
	logic [6:0] out_char;
	logic       out_last;

	sbda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sbda_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (VALUE_BITS'(number.data)),
		.out_ready (text.ready),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_char  (out_char),
		.out_last  (out_last)
	);

	assign number.ready        = in_ready;
	assign text.valid          = out_valid;
	assign text.data.character = out_char;
	assign text.data.last      = out_last;

endmodule
